/* rtl/dual_stepper_half_step_sequencer_macros.svh */
// assertion macros used by the dual stepper sequencer checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef DUAL_STEPPER_HALF_STEP_SEQUENCER_MACROS_SVH
`define DUAL_STEPPER_HALF_STEP_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DSSQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dssq assertion failed");

// next-cycle implication, disabled while reset is asserted
`define DSSQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dssq assertion failed");

`endif

/* rtl/dssq_pkg.sv */
// package for the dual stepper half-step sequencer
// widths, stream field positions, register indexes, coil table; no dependencies
`default_nettype none

package dssq_pkg;

  localparam int DEFAULT_STEP_COUNT_WIDTH = 20;
  localparam int DEFAULT_DELAY_WIDTH      = 16;

  localparam int DELAY_REG_WIDTH = 16;
  localparam int MAX_STEPS_WIDTH = 20;
  localparam int CFG_DATA_WIDTH  = 20;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam int ANGLE_WIDTH     = 16;
  localparam int PHASE_WIDTH     = 4;
  localparam int COIL_WIDTH      = 4;
  localparam int RAW_STEPS_WIDTH = 20;

  // floor(a*512/45) == (a * RECIP_45) >> RECIP_SHIFT for every 16-bit a
  localparam int                      RECIP_WIDTH   = 25;
  localparam int                      RECIP_SHIFT   = 21;
  localparam logic [RECIP_WIDTH-1:0]  RECIP_45      = 25'd23860930;
  localparam int                      PRODUCT_WIDTH = ANGLE_WIDTH + RECIP_WIDTH;

  localparam logic [DELAY_REG_WIDTH-1:0] DELAY_RESET     = 16'd2;
  localparam logic [MAX_STEPS_WIDTH-1:0] MAX_STEPS_RESET = 20'd4096;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_PHASE_DELAY     = 2'd0,
    CFG_MAX_STEPS_YAW   = 2'd1,
    CFG_MAX_STEPS_PITCH = 2'd2
  } cfg_reg_e;

  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_MOVE     = 1'b1;
  localparam logic MOTOR_YAW   = 1'b0;
  localparam logic MOTOR_PITCH = 1'b1;
  localparam logic DIR_FWD     = 1'b0;
  localparam logic DIR_BWD     = 1'b1;

  localparam logic [PHASE_WIDTH-1:0] PHASE_FIRST = 4'd0;
  localparam logic [PHASE_WIDTH-1:0] PHASE_OFF   = 4'd8;
  localparam logic [COIL_WIDTH-1:0]  COILS_OFF   = 4'd0;

  // input tdata layout
  localparam int IN_MOTOR_BIT    = 0;
  localparam int IN_DIR_BIT      = 1;
  localparam int IN_ANGLE_LSB    = 2;
  localparam int IN_HOME_BIT     = 18;
  localparam int IN_TDATA_WIDTH  = 24;

  // output tdata layout
  localparam int OUT_YAW_LSB     = 0;
  localparam int OUT_PITCH_LSB   = 4;
  localparam int OUT_BUSY_BIT    = 8;
  localparam int OUT_DONE_BIT    = 9;
  localparam int OUT_REJECT_BIT  = 10;
  localparam int OUT_TDATA_WIDTH = 16;

  function automatic logic [COIL_WIDTH-1:0] coil_pattern(input logic [PHASE_WIDTH-1:0] phase);
    logic [COIL_WIDTH-1:0] pat;
    case (phase)
      4'd0:    pat = 4'd9;
      4'd1:    pat = 4'd1;
      4'd2:    pat = 4'd3;
      4'd3:    pat = 4'd2;
      4'd4:    pat = 4'd6;
      4'd5:    pat = 4'd4;
      4'd6:    pat = 4'd12;
      4'd7:    pat = 4'd8;
      default: pat = COILS_OFF;
    endcase
    return pat;
  endfunction

  function automatic logic [PHASE_WIDTH-1:0] next_phase(input logic [PHASE_WIDTH-1:0] phase,
                                                        input logic                   dir);
    logic [PHASE_WIDTH-1:0] nxt;
    if (dir == DIR_FWD) begin
      nxt = (phase >= PHASE_OFF) ? PHASE_FIRST : phase + 4'd1;
    end else begin
      nxt = (phase == PHASE_FIRST) ? PHASE_OFF : phase - 4'd1;
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

/* rtl/dual_stepper_half_step_sequencer.sv */
// top level of the dual stepper half-step sequencer (yaw and pitch motors)
// depends on dssq_pkg
`default_nettype none

// Drives two four-wire steppers through eight half-step patterns plus an
// all-off position. Every input beat (a tick or a move command) gives exactly
// one result beat with both coil drives and the busy, done and rejected
// flags. One beat is taken per clock cycle while m_axis_tready does not stall
// the result register; the input register takes the beat and the result
// register takes its result, with all per-beat work (the step-count
// multiply, limit compares and phase update) in the single stage between
// them. A command's step count is floor(angle*512/45), clamped to the counter
// width and to that motor's limit. Steps are spaced at least phase_delay_ticks
// ticks apart. The user must write registers through cfg_we_i / cfg_index_i /
// cfg_wdata_i only while the block is idle; the block does not enforce this.
// Index 0 is the delay, 1 the yaw limit, 2 the pitch limit.
module dual_stepper_half_step_sequencer #(
  parameter int STEP_COUNT_WIDTH = dssq_pkg::DEFAULT_STEP_COUNT_WIDTH,
  parameter int DELAY_WIDTH      = dssq_pkg::DEFAULT_DELAY_WIDTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [dssq_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index_i,
  input  logic [dssq_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // motor_select, move_direction, angle_units[15:0], start_from_home, zero pad
  input  logic [dssq_pkg::IN_TDATA_WIDTH-1:0]   s_axis_tdata,
  // operation
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // yaw_coils[3:0], pitch_coils[3:0], busy_res, move_done, command_rejected, zero pad
  output logic [dssq_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata
);
  import dssq_pkg::*;

  localparam int CntBase     = (RAW_STEPS_WIDTH > MAX_STEPS_WIDTH) ? RAW_STEPS_WIDTH
                                                                   : MAX_STEPS_WIDTH;
  localparam int CntCmpWidth = (STEP_COUNT_WIDTH > CntBase) ? STEP_COUNT_WIDTH : CntBase;
  localparam int DlyCmpWidth = (DELAY_WIDTH > DELAY_REG_WIDTH) ? DELAY_WIDTH : DELAY_REG_WIDTH;

  // configuration registers
  logic [DELAY_REG_WIDTH-1:0] delay_q;
  logic [MAX_STEPS_WIDTH-1:0] max_yaw_q, max_pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= DELAY_RESET;
      max_yaw_q   <= MAX_STEPS_RESET;
      max_pitch_q <= MAX_STEPS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PHASE_DELAY:     delay_q     <= cfg_wdata_i[DELAY_REG_WIDTH-1:0];
        CFG_MAX_STEPS_YAW:   max_yaw_q   <= cfg_wdata_i[MAX_STEPS_WIDTH-1:0];
        CFG_MAX_STEPS_PITCH: max_pitch_q <= cfg_wdata_i[MAX_STEPS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                   in_valid_q, in_valid_d;
  logic                   in_op_q, in_motor_q, in_dir_q, in_home_q;
  logic [ANGLE_WIDTH-1:0] in_angle_q;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_WIDTH-1:0] out_data_q, out_data_d;
  logic                   advance, in_load, process;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_load       = s_axis_tvalid && s_axis_tready;
  assign process       = in_valid_q && advance;

  always_comb begin
    if (in_load) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_op_q    <= s_axis_tuser;
      in_motor_q <= s_axis_tdata[IN_MOTOR_BIT];
      in_dir_q   <= s_axis_tdata[IN_DIR_BIT];
      in_angle_q <= s_axis_tdata[IN_ANGLE_LSB +: ANGLE_WIDTH];
      in_home_q  <= s_axis_tdata[IN_HOME_BIT];
    end
  end

  // sequencer state
  logic [PHASE_WIDTH-1:0]      yaw_phase_q, yaw_phase_d, pitch_phase_q, pitch_phase_d;
  logic [DELAY_WIDTH-1:0]      ticks_q, ticks_d;
  logic [STEP_COUNT_WIDTH-1:0] steps_left_q, steps_left_d;
  logic                        moving_q, moving_d;
  logic                        act_motor_q, act_motor_d, act_dir_q, act_dir_d;
  logic [COIL_WIDTH-1:0]       yaw_coil_q, yaw_coil_d, pitch_coil_q, pitch_coil_d;

  // step count of a command
  logic [PRODUCT_WIDTH-1:0]    product;
  logic [RAW_STEPS_WIDTH-1:0]  raw_steps;
  logic [CntCmpWidth-1:0]      raw_ext, smax_ext, lim_ext, sat_ext, cnt_ext;
  logic [STEP_COUNT_WIDTH-1:0] cmd_steps, steps_dec;

  // tick pacing
  logic [DELAY_WIDTH-1:0]      ticks_max, ticks_inc;
  logic [DlyCmpWidth-1:0]      delay_ext, tmax_ext, delay_eff;
  logic                        step_due;
  logic                        done, rejected;

  always_comb begin
    product   = PRODUCT_WIDTH'(in_angle_q) * PRODUCT_WIDTH'(RECIP_45);
    raw_steps = product[RECIP_SHIFT +: RAW_STEPS_WIDTH];
    raw_ext   = CntCmpWidth'(raw_steps);
    smax_ext  = CntCmpWidth'({STEP_COUNT_WIDTH{1'b1}});
    lim_ext   = CntCmpWidth'((in_motor_q == MOTOR_PITCH) ? max_pitch_q : max_yaw_q);
    sat_ext   = (raw_ext > smax_ext) ? smax_ext : raw_ext;
    cnt_ext   = (sat_ext > lim_ext) ? lim_ext : sat_ext;
    cmd_steps = cnt_ext[STEP_COUNT_WIDTH-1:0];
    steps_dec = steps_left_q - STEP_COUNT_WIDTH'(1);

    ticks_max = {DELAY_WIDTH{1'b1}};
    ticks_inc = (ticks_q == ticks_max) ? ticks_q : ticks_q + DELAY_WIDTH'(1);
    delay_ext = DlyCmpWidth'(delay_q);
    tmax_ext  = DlyCmpWidth'(ticks_max);
    delay_eff = (delay_ext > tmax_ext) ? tmax_ext : delay_ext;
    step_due  = moving_q && (DlyCmpWidth'(ticks_inc) >= delay_eff);
  end

  always_comb begin
    yaw_phase_d   = yaw_phase_q;
    pitch_phase_d = pitch_phase_q;
    ticks_d       = ticks_q;
    steps_left_d  = steps_left_q;
    moving_d      = moving_q;
    act_motor_d   = act_motor_q;
    act_dir_d     = act_dir_q;
    yaw_coil_d    = yaw_coil_q;
    pitch_coil_d  = pitch_coil_q;
    done          = 1'b0;
    rejected      = 1'b0;

    if (in_op_q == OP_TICK) begin
      ticks_d = ticks_inc;
      if (step_due) begin
        if (act_motor_q == MOTOR_YAW) begin
          yaw_coil_d  = coil_pattern(yaw_phase_q);
          yaw_phase_d = next_phase(yaw_phase_q, act_dir_q);
        end else begin
          pitch_coil_d  = coil_pattern(pitch_phase_q);
          pitch_phase_d = next_phase(pitch_phase_q, act_dir_q);
        end
        ticks_d      = '0;
        steps_left_d = steps_dec;
        // last step: pattern is dropped at once for coils off
        if (steps_dec == '0) begin
          if (act_motor_q == MOTOR_YAW) begin
            yaw_coil_d = COILS_OFF;
          end else begin
            pitch_coil_d  = COILS_OFF;
            pitch_phase_d = PHASE_FIRST;
          end
          moving_d = 1'b0;
          done     = 1'b1;
        end
      end
    end else if (moving_q) begin
      rejected = 1'b1;
    end else begin
      if (in_home_q) begin
        if (in_motor_q == MOTOR_YAW) begin
          yaw_phase_d = (in_dir_q == DIR_FWD) ? PHASE_FIRST : PHASE_OFF;
          yaw_coil_d  = COILS_OFF;
        end else begin
          pitch_phase_d = (in_dir_q == DIR_FWD) ? PHASE_FIRST : PHASE_OFF;
          pitch_coil_d  = COILS_OFF;
        end
      end
      act_motor_d = in_motor_q;
      act_dir_d   = in_dir_q;
      if (cmd_steps == '0) begin
        if (in_motor_q == MOTOR_YAW) begin
          yaw_coil_d = COILS_OFF;
        end else begin
          pitch_coil_d  = COILS_OFF;
          pitch_phase_d = PHASE_FIRST;
        end
        moving_d     = 1'b0;
        steps_left_d = '0;
        done         = 1'b1;
      end else begin
        steps_left_d = cmd_steps;
        moving_d     = 1'b1;
      end
    end

    out_data_d                               = '0;
    out_data_d[OUT_YAW_LSB +: COIL_WIDTH]    = yaw_coil_d;
    out_data_d[OUT_PITCH_LSB +: COIL_WIDTH]  = pitch_coil_d;
    out_data_d[OUT_BUSY_BIT]                 = moving_d;
    out_data_d[OUT_DONE_BIT]                 = done;
    out_data_d[OUT_REJECT_BIT]               = rejected;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_phase_q   <= PHASE_FIRST;
      pitch_phase_q <= PHASE_FIRST;
      ticks_q       <= '0;
      steps_left_q  <= '0;
      moving_q      <= 1'b0;
      act_motor_q   <= MOTOR_YAW;
      act_dir_q     <= DIR_FWD;
      yaw_coil_q    <= COILS_OFF;
      pitch_coil_q  <= COILS_OFF;
    end else if (process) begin
      yaw_phase_q   <= yaw_phase_d;
      pitch_phase_q <= pitch_phase_d;
      ticks_q       <= ticks_d;
      steps_left_q  <= steps_left_d;
      moving_q      <= moving_d;
      act_motor_q   <= act_motor_d;
      act_dir_q     <= act_dir_d;
      yaw_coil_q    <= yaw_coil_d;
      pitch_coil_q  <= pitch_coil_d;
    end
  end

  // result register
  always_comb begin
    if (process) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

/* rtl/dssq_checker.sv */
// port-level checks for the dual stepper half-step sequencer, bound to the top level
// depends on dssq_pkg and dual_stepper_half_step_sequencer_macros.svh
`default_nettype none
`include "dual_stepper_half_step_sequencer_macros.svh"

module dssq_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 m_axis_tvalid,
  input wire logic                                 m_axis_tready,
  input wire logic [dssq_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata
);
  import dssq_pkg::*;

  logic res_busy, res_done, res_rej;

  assign res_busy = m_axis_tdata[OUT_BUSY_BIT];
  assign res_done = m_axis_tdata[OUT_DONE_BIT];
  assign res_rej  = m_axis_tdata[OUT_REJECT_BIT];

  // a stalled result beat stays put
  `DSSQ_ASSERT_NEXT(a_res_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // a beat cannot both finish a move and reject a command
  `DSSQ_ASSERT_IMPL(a_done_xor_rej, m_axis_tvalid, !(res_done && res_rej))
  // a finished move leaves the block idle
  `DSSQ_ASSERT_IMPL(a_done_idle, m_axis_tvalid && res_done, !res_busy)
  // rejection only happens while a move keeps running
  `DSSQ_ASSERT_IMPL(a_rej_busy, m_axis_tvalid && res_rej, res_busy)

endmodule

bind dual_stepper_half_step_sequencer dssq_checker u_dssq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
